/* hdl/ffba_pkg.sv */
// ffba_pkg: shared types and constants for the first-fit block allocator
// no dependencies

package ffba_pkg;

  // payload field widths
  localparam int REQ_W  = 13;
  localparam int OFF_W  = 13;
  localparam int NEED_W = 11;  // words needed for a request, header included
  localparam int PW_W   = OFF_W - 3;  // payload word index from a byte offset

  // request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_SPLIT = 4'b1000
  } state_t;

endpackage

/* hdl/ffba_ram.sv */
// ffba_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/first_fit_block_allocator_top.sv */
// first_fit_block_allocator_top: first-fit allocator over a pool of 8-byte words
// depends on ffba_pkg and ffba_ram (size store and allocated-mark store)

// A start is taken when busy is low. A free transaction's result strobes on
// done in the next cycle and busy never rises. An allocate transaction walks
// the block headers, one header read per cycle out of the size and mark rams:
// busy stays high while the walk visits headers, and while the header of a
// split-off free remainder is written (a second write on the same ram port).
// done strobes in the cycle busy falls, so a new start may be taken in the
// same cycle a result is shown. Results cannot be held off: status and
// payload_offset are only sure to hold a result in the done cycle. After
// reset the block is busy while it writes the header of the single free
// block that covers words 1 to POOL_WORDS-1.

module first_fit_block_allocator_top
  import ffba_pkg::*;
#(
  parameter int POOL_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  logic [REQ_W-1:0]  req_bytes,
  input  logic [OFF_W-1:0]  free_offset,
  output logic              busy,
  output logic              done,
  output logic [1:0]        status,
  output logic [OFF_W-1:0]  payload_offset
);

  localparam int AW = $clog2(POOL_WORDS);
  // compare width wide enough for block sizes, word indexes and needed words
  localparam int CW = (AW + 1 > NEED_W) ? AW + 1 : NEED_W;
  // width for the decoded free word index
  localparam int FW = (AW + 1 > PW_W) ? AW + 1 : PW_W;

  state_t             state;
  logic [AW-1:0]      w;           // header word under inspection
  logic [NEED_W-1:0]  need;        // words needed by the current request
  logic [AW-1:0]      split_addr;  // header word of the split-off remainder
  logic [AW-1:0]      split_size;

  // ram ports
  logic               size_we;
  logic               mark_we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      size_wdata;
  logic [0:0]         mark_wdata;
  logic [AW-1:0]      size_rdata;
  logic [0:0]         mark_rdata;

  // walk datapath
  logic               accept;
  logic [REQ_W:0]     req_round;
  logic [NEED_W-1:0]  need_in;
  logic [AW:0]        sum_w;
  logic [AW:0]        limit;
  logic               broken;
  logic               fits;
  logic [CW-1:0]      rem;
  logic               do_split;
  logic               at_end;
  logic [CW-1:0]      split_sum;
  logic [AW:0]        w_p1;
  logic [OFF_W-1:0]   offset;

  // free datapath
  logic [PW_W-1:0]    pw;
  logic [FW-1:0]      pw_m1;
  logic               free_ok;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // words needed: bytes rounded up to whole words plus the header word
  assign req_round = {1'b0, req_bytes} + (REQ_W + 1)'(7);
  assign need_in   = NEED_W'(req_round[REQ_W:3]) + NEED_W'(1);

  // header checks on the word just read
  assign sum_w    = (AW + 1)'(w) + (AW + 1)'(size_rdata);
  assign limit    = (AW + 1)'(POOL_WORDS) - (AW + 1)'(w);
  assign broken   = (size_rdata == '0) || ((AW + 1)'(size_rdata) > limit);
  assign fits     = !mark_rdata[0] && (CW'(size_rdata) >= CW'(need));
  assign rem      = CW'(size_rdata) - CW'(need);
  assign do_split = (rem > CW'(1));
  assign at_end   = (sum_w >= (AW + 1)'(POOL_WORDS));
  assign split_sum = CW'(w) + CW'(need);

  // payload byte offset, masked to the port width
  assign w_p1   = (AW + 1)'(w) + (AW + 1)'(1);
  assign offset = OFF_W'({w_p1, 3'b000});

  // free: header sits one word before the payload
  assign pw      = free_offset[OFF_W-1:3];
  assign pw_m1   = FW'(pw) - FW'(1);
  assign free_ok = (pw != '0) && (pw_m1 < FW'(POOL_WORDS));

  // next header is read while the current one is judged
  assign raddr = (state == S_WALK && !at_end) ? sum_w[AW-1:0] : AW'(1);

  // ram write selection
  always_comb begin
    size_we    = 1'b0;
    mark_we    = 1'b0;
    waddr      = w;
    size_wdata = size_rdata;
    mark_wdata = 1'b0;
    unique case (state)
      S_INIT: begin
        // initial free block covering the pool from word 1 to POOL_WORDS-1
        size_we    = 1'b1;
        mark_we    = 1'b1;
        waddr      = AW'(1);
        size_wdata = AW'(POOL_WORDS - 1);
      end
      S_IDLE: begin
        if (accept && func == FUNC_FREE && free_ok) begin
          mark_we = 1'b1;
          waddr   = pw_m1[AW-1:0];
        end
      end
      S_WALK: begin
        if (!broken && fits) begin
          size_we    = 1'b1;
          mark_we    = 1'b1;
          size_wdata = do_split ? AW'(need) : size_rdata;
          mark_wdata = 1'b1;
        end
      end
      S_SPLIT: begin
        // header of the free remainder
        size_we    = 1'b1;
        mark_we    = 1'b1;
        waddr      = split_addr;
        size_wdata = split_size;
      end
      default: ;
    endcase
  end

  ffba_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_WORDS)
  ) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (waddr),
    .wdata (size_wdata),
    .raddr (raddr),
    .rdata (size_rdata)
  );

  ffba_ram #(
    .WIDTH (1),
    .DEPTH (POOL_WORDS)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (waddr),
    .wdata (mark_wdata),
    .raddr (raddr),
    .rdata (mark_rdata)
  );

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (func == FUNC_FREE) begin
              // free finishes at once; the mark write, if the offset is valid, happens this edge
              done           <= 1'b1;
              status         <= ST_FREED;
              payload_offset <= '0;
            end else begin
              // header at word 1 is being read this cycle
              need  <= need_in;
              w     <= AW'(1);
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          priority if (broken) begin
            // broken chain ends the walk like the end of the pool
            done           <= 1'b1;
            status         <= ST_NOFIT;
            payload_offset <= '0;
            state          <= S_IDLE;
          end else if (fits) begin
            status         <= ST_ALLOC;
            payload_offset <= offset;
            if (do_split) begin
              split_addr <= split_sum[AW-1:0];
              split_size <= AW'(rem);
              state      <= S_SPLIT;
            end else begin
              // remainder of one word or none stays with the block
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else if (at_end) begin
            done           <= 1'b1;
            status         <= ST_NOFIT;
            payload_offset <= '0;
            state          <= S_IDLE;
          end else begin
            w <= sum_w[AW-1:0];
          end
        end
        S_SPLIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result only follows a free accept, a finished walk or a split write
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_WALK || state == S_SPLIT ||
                   (start && !busy && func == FUNC_FREE)))
    else $error("result strobe without a finishing transaction");

  // split write is always followed by its allocate result
  a_split_done: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT |=> done && status == ST_ALLOC)
    else $error("split did not complete an allocation");

  // failed or free results carry a zero offset
  a_zero_offset: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_ALLOC) |-> payload_offset == '0)
    else $error("nonzero offset on a non-allocate result");

  // split header lands inside the pool
  a_split_in_pool: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT |-> (AW + 1)'(split_addr) < (AW + 1)'(POOL_WORDS))
    else $error("split header outside the pool");

endmodule
